>>> rtl/tpc_pkg.sv
// touch point calibrator package: shared types, constants and helper functions
// used by every rtl file of the calibrator; has no dependencies of its own
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int CoordW = 12;
  localparam int ByteW  = 8;

  // reset sizes and the landscape panel size
  localparam logic [CoordW-1:0] WIDTH_RESET  = 12'd240;
  localparam logic [CoordW-1:0] HEIGHT_RESET = 12'd320;
  localparam logic [CoordW-1:0] LAND_W       = 12'd320;
  localparam logic [CoordW-1:0] LAND_H       = 12'd240;

  // raw sample limits and landscape inversion
  localparam logic [CoordW-1:0] RAW_X_LIMIT = 12'd240;
  localparam logic [CoordW-1:0] RAW_Y_LIMIT = 12'd320;
  localparam logic [CoordW-1:0] LAND_INV    = 12'd239;

  // calibration points: x spans 36..228 (192), y spans 23..292 (269)
  localparam logic [CoordW-1:0] CAL_X_LO = 12'd36;
  localparam logic [CoordW-1:0] CAL_Y_LO = 12'd23;
  localparam int DxW = 8;   // raw x below 240, so x - 36 fits 8 bits
  localparam int DyW = 9;   // raw y below 320, so y - 23 fits 9 bits
  localparam logic [DxW-1:0] X_GAIN = 8'd239;
  localparam logic [DyW-1:0] Y_GAIN = 9'd319;
  localparam int PxW = 16;  // max 203 * 239
  localparam int PyW = 17;  // max 296 * 319

  // x: divide by 192 as shift by 6 then divide by 3 (683 / 2048)
  localparam int X_SPAN_SHIFT = 6;
  localparam int PxHiW        = PxW - X_SPAN_SHIFT;
  localparam logic [PxHiW-1:0] DIV3_MUL = 10'd683;
  localparam int DIV3_SHIFT   = 11;
  // y: divide by 269 as multiply by ceil(2^25 / 269)
  localparam logic [PyW-1:0] RECIP_269 = 17'd124738;
  localparam int RECIP_SHIFT  = 25;
  localparam int QW = 9;    // both quotients below 512

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_LAND,
    MODE_PORT
  } mode_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // decoded poll after the input register
  typedef struct packed {
    logic              reject;
    mode_t             mode;
    logic [CoordW-1:0] rx;
    logic [CoordW-1:0] ry;
  } poll_t;

  // poll with the calibration products
  typedef struct packed {
    logic              reject;
    mode_t             mode;
    logic [CoordW-1:0] rx;
    logic [CoordW-1:0] ry;
    logic [PxW-1:0]    px;
    logic [PyW-1:0]    py;
  } prod_t;

  function automatic logic [CoordW-1:0] clamp_to(input logic [CoordW-1:0] v,
                                                 input logic [CoordW-1:0] size);
    logic [CoordW-1:0] r;
    if (size == '0) begin
      r = '0;
    end else if (v >= size) begin
      r = size - 12'd1;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/touch_point_calibrator.sv
// top level of the touch point calibrator: configuration registers and the
// three-stage pipeline; depends on tpc_pkg, tpc_front, tpc_mul and tpc_back
`timescale 1ns / 1ps

// usage
//   one request on the input channel carries one touch poll: bus_ok,
//   touches and the four coordinate bytes. every request gives exactly
//   one result request: pressed with a new mapped point, or released with
//   the point of the last press.
//   channels use valid/ready; a request moves when both are high.
// latency and throughput
//   a result shows on out_valid once its poll has passed the input, product
//   and output registers. one poll per cycle is taken while in_ready is
//   high; each stage holds one request and fills bubbles, so in_ready
//   stays high while any stage has room.
// stalls
//   when out_ready is low the output register holds its result and the
//   pipeline keeps filling; in_ready drops once all three stages are full.
// reset
//   rst (synchronous) empties the pipeline, clears the held point to 0,0
//   and sets the screen size to 240 x 320 (calibrated portrait mode).
// configuration
//   cfg_we writes cfg_data to the register chosen by cfg_index; write only
//   while no request is in flight.
module touch_point_calibrator (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  tpc_pkg::reg_idx_t          cfg_index,
  input  logic [tpc_pkg::CoordW-1:0] cfg_data,
  // poll request
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       bus_ok,
  input  logic [7:0]                 touches,
  input  logic [7:0]                 x_high,
  input  logic [7:0]                 x_low,
  input  logic [7:0]                 y_high,
  input  logic [7:0]                 y_low,
  // result request
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       pressed,
  output logic [tpc_pkg::CoordW-1:0] point_x,
  output logic [tpc_pkg::CoordW-1:0] point_y
);
  import tpc_pkg::*;

  // screen size registers, also select the mapping mode
  logic [CoordW-1:0] screen_width;
  logic [CoordW-1:0] screen_height;

  // stage handshakes
  logic  s_valid;
  logic  s_ready;
  poll_t s_data;
  logic  m_valid;
  logic  m_ready;
  prod_t m_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default:    screen_width  <= screen_width;
      endcase
    end
  end

  // stage 1: raw assembly, rejection and mode decode
  tpc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .bus_ok        (bus_ok),
    .touches       (touches),
    .x_high        (x_high),
    .x_low         (x_low),
    .y_high        (y_high),
    .y_low         (y_low),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_data        (s_data)
  );

  // stage 2: calibration offsets and gain multiplies
  tpc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
  );

  // stage 3: reciprocal divides, mode select, clamp, held point, output
  tpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data        (m_data),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pressed       (pressed),
    .point_x       (point_x),
    .point_y       (point_y)
  );

endmodule

>>> rtl/tpc_front.sv
// input stage: assembles raw coordinates, decides rejection and mapping mode
// depends on tpc_pkg
`timescale 1ns / 1ps

module tpc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      bus_ok,
  input  logic [7:0]                touches,
  input  logic [7:0]                x_high,
  input  logic [7:0]                x_low,
  input  logic [7:0]                y_high,
  input  logic [7:0]                y_low,
  input  logic [tpc_pkg::CoordW-1:0] screen_width,
  input  logic [tpc_pkg::CoordW-1:0] screen_height,
  output logic                      s_valid,
  input  logic                      s_ready,
  output tpc_pkg::poll_t            s_data
);
  import tpc_pkg::*;

  poll_t poll_next;

  assign in_ready = !s_valid || s_ready;

  always_comb begin
    poll_next.rx = {x_high[3:0], x_low};
    poll_next.ry = {y_high[3:0], y_low};
    poll_next.reject = !bus_ok || (touches == 8'd0) ||
                       (poll_next.rx >= RAW_X_LIMIT) || (poll_next.ry >= RAW_Y_LIMIT);
    if (screen_width == LAND_W && screen_height == LAND_H) begin
      poll_next.mode = MODE_LAND;
    end else if (screen_width == WIDTH_RESET && screen_height == HEIGHT_RESET) begin
      poll_next.mode = MODE_PORT;
    end else begin
      poll_next.mode = MODE_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_data <= poll_next;
    end
  end

  // an accepted press is always inside the raw window
  a_press_in_window: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !s_data.reject) |-> (s_data.rx < RAW_X_LIMIT && s_data.ry < RAW_Y_LIMIT))
    else $error("press outside raw window");

endmodule

>>> rtl/tpc_mul.sv
// product stage: offsets raw samples by the calibration low points and scales
// them by the output span; depends on tpc_pkg
`timescale 1ns / 1ps

module tpc_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  tpc_pkg::poll_t s_data,
  output logic           m_valid,
  input  logic           m_ready,
  output tpc_pkg::prod_t m_data
);
  import tpc_pkg::*;

  logic [CoordW-1:0] dx_full;
  logic [CoordW-1:0] dy_full;
  logic [DxW-1:0]    dx;
  logic [DyW-1:0]    dy;
  logic [PxW-1:0]    px;
  logic [2*DyW-1:0]  py_full;
  prod_t             prod_next;

  assign s_ready = !m_valid || m_ready;

  always_comb begin
    // at or below the low point the map gives zero
    dx_full = (s_data.rx > CAL_X_LO) ? (s_data.rx - CAL_X_LO) : '0;
    dy_full = (s_data.ry > CAL_Y_LO) ? (s_data.ry - CAL_Y_LO) : '0;
    dx      = dx_full[DxW-1:0];
    dy      = dy_full[DyW-1:0];
    px      = {{(PxW-DxW){1'b0}}, dx} * {{(PxW-DxW){1'b0}}, X_GAIN};
    py_full = {{DyW{1'b0}}, dy} * {{DyW{1'b0}}, Y_GAIN};
    prod_next.reject = s_data.reject;
    prod_next.mode   = s_data.mode;
    prod_next.rx     = s_data.rx;
    prod_next.ry     = s_data.ry;
    prod_next.px     = px;
    prod_next.py     = py_full[PyW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s_ready) begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      m_data <= prod_next;
    end
  end

  // a stalled stage keeps its request
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
    else $error("product stage lost a stalled request");

endmodule

>>> rtl/tpc_back.sv
// result stage: divides the products, selects the mapping, clamps to the
// screen size, keeps the held point and drives the output register; uses tpc_pkg
`timescale 1ns / 1ps

module tpc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       m_valid,
  output logic                       m_ready,
  input  tpc_pkg::prod_t             m_data,
  input  logic [tpc_pkg::CoordW-1:0] screen_width,
  input  logic [tpc_pkg::CoordW-1:0] screen_height,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       pressed,
  output logic [tpc_pkg::CoordW-1:0] point_x,
  output logic [tpc_pkg::CoordW-1:0] point_y
);
  import tpc_pkg::*;

  logic [PxHiW-1:0]      px_hi;
  logic [2*PxHiW-1:0]    qx_prod;
  logic [2*PyW-1:0]      qy_prod;
  logic [QW-1:0]         qx;
  logic [QW-1:0]         qy;
  logic [CoordW-1:0]     sx;
  logic [CoordW-1:0]     sy;
  logic [CoordW-1:0]     held_x;
  logic [CoordW-1:0]     held_y;
  logic                  load;

  assign m_ready = !out_valid || out_ready;
  assign load    = m_valid && m_ready;

  always_comb begin
    px_hi   = m_data.px[PxW-1:X_SPAN_SHIFT];
    qx_prod = {{PxHiW{1'b0}}, px_hi} * {{PxHiW{1'b0}}, DIV3_MUL};
    qy_prod = {{PyW{1'b0}}, m_data.py} * {{PyW{1'b0}}, RECIP_269};
    qx      = qx_prod[DIV3_SHIFT +: QW];
    qy      = qy_prod[RECIP_SHIFT +: QW];
    unique case (m_data.mode)
      MODE_LAND: begin
        sx = m_data.ry;
        sy = LAND_INV - m_data.rx;
      end
      MODE_PORT: begin
        sx = {{(CoordW-QW){1'b0}}, qx};
        sy = {{(CoordW-QW){1'b0}}, qy};
      end
      default: begin
        sx = m_data.rx;
        sy = m_data.ry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
    end else begin
      if (m_ready) begin
        out_valid <= m_valid;
      end
      if (load && !m_data.reject) begin
        held_x <= clamp_to(sx, screen_width);
        held_y <= clamp_to(sy, screen_height);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pressed <= !m_data.reject;
      if (m_data.reject) begin
        point_x <= held_x;
        point_y <= held_y;
      end else begin
        point_x <= clamp_to(sx, screen_width);
        point_y <= clamp_to(sy, screen_height);
      end
    end
  end

  // whatever is shown, pressed or released, matches the held point
  a_out_is_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (point_x == held_x && point_y == held_y))
    else $error("result differs from held point");

  // the held point moves only with a loaded press
  a_held_only_on_press: assert property (@(posedge clk) disable iff (rst)
    !(load && !m_data.reject) |=> ($stable(held_x) && $stable(held_y)))
    else $error("held point changed without a press");

  // a released result keeps the point of the last press
  a_release_keeps_point: assert property (@(posedge clk) disable iff (rst)
    (load && m_data.reject) |=> (!pressed && point_x == $past(held_x)
                                 && point_y == $past(held_y)))
    else $error("release did not repeat the held point");

endmodule
